### hdl/best_score_table_with_ranked_readout_defines.svh
// Assertion macros shared by the best-score table RTL.
// Expects clk and rst_n in the scope where a macro is used.
`ifndef BEST_SCORE_TABLE_WITH_RANKED_READOUT_DEFINES_SVH
`define BEST_SCORE_TABLE_WITH_RANKED_READOUT_DEFINES_SVH

// same-cycle implication
`define BST_CHECK_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bst check failed");

// next-cycle implication
`define BST_CHECK_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bst check failed");

`endif

### hdl/bst_pkg.sv
// Shared types, codes and helpers for the best-score table.
// No dependencies.
package bst_pkg;

  localparam int NAME_W  = 64;
  localparam int SCORE_W = 24;
  localparam int SLOT_W  = 6;

  localparam logic [1:0] ACT_SUBMIT = 2'd0;
  localparam logic [1:0] ACT_LIST   = 2'd1;
  localparam logic [1:0] ACT_CLEAR  = 2'd2;

  typedef struct packed {
    logic               rd_en;
    logic [SLOT_W-1:0]  rd_addr;
    logic               wr_en;
    logic [SLOT_W-1:0]  wr_addr;
    logic [NAME_W-1:0]  wr_name;
    logic [SCORE_W-1:0] wr_score;
    logic               clr;
  } mem_req_t;

  typedef struct packed {
    logic [NAME_W-1:0]  name;
    logic [SCORE_W-1:0] score;
  } mem_rsp_t;

  typedef struct packed {
    logic               valid;
    logic [SLOT_W-1:0]  slot;
    logic               written;
    logic [NAME_W-1:0]  name;
    logic [SCORE_W-1:0] score;
    logic               last;
  } res_t;

  // zero every byte from the first zero byte upward
  function automatic logic [NAME_W-1:0] canon_name(input logic [NAME_W-1:0] n);
    logic [NAME_W-1:0] r;
    logic              stop;
    r    = '0;
    stop = 1'b0;
    for (int b = 0; b < 8; b++) begin
      if (n[8*b +: 8] == 8'h00) stop = 1'b1;
      if (!stop) r[8*b +: 8] = n[8*b +: 8];
    end
    return r;
  endfunction

endpackage

### hdl/bst_mem.sv
// Table memory: one name+score word per slot, one read and one write port.
// Per-slot valid bits make unwritten or cleared slots read as zero. Uses bst_pkg.
module bst_mem #(
  parameter int ENTRIES = 40
) (
  input  logic              clk,
  input  logic              rst_n,
  input  bst_pkg::mem_req_t mem_req,
  output bst_pkg::mem_rsp_t mem_rsp
);

  localparam int AW = $clog2(ENTRIES);

  bst_pkg::mem_rsp_t mem_q [ENTRIES];
  logic [ENTRIES-1:0] vld_r;
  bst_pkg::mem_rsp_t  rdata_r;
  logic               rvld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (mem_req.clr) begin
      vld_r <= '0;
    end else if (mem_req.wr_en) begin
      vld_r[mem_req.wr_addr[AW-1:0]] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_req.wr_en) begin
      mem_q[mem_req.wr_addr[AW-1:0]] <= '{name: mem_req.wr_name, score: mem_req.wr_score};
    end
  end

  always_ff @(posedge clk) begin
    if (mem_req.rd_en) begin
      rdata_r <= mem_q[mem_req.rd_addr[AW-1:0]];
      rvld_r  <= vld_r[mem_req.rd_addr[AW-1:0]];
    end
  end

  assign mem_rsp = rvld_r ? rdata_r : '0;

endmodule

### hdl/bst_seq.sv
// Sequencer: scans the table memory once per submit, and for a list once per ranked entry plus a last pass.
// Depends on bst_pkg and the assertion macro header.
`include "best_score_table_with_ranked_readout_defines.svh"
module bst_seq #(
  parameter int ENTRIES = 40
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    in_action,
  input  logic [bst_pkg::NAME_W-1:0]    in_name,
  input  logic [bst_pkg::SCORE_W-1:0]   in_score,
  output bst_pkg::mem_req_t             mem_req,
  input  bst_pkg::mem_rsp_t             mem_rsp,
  output bst_pkg::res_t                 res,
  input  logic                          res_ready
);

  localparam int AW = $clog2(ENTRIES);
  localparam logic [AW-1:0] LAST = AW'(ENTRIES - 1);

  typedef enum logic [2:0] {
    ST_IDLE, ST_SUB_SCAN, ST_SUB_END, ST_LST_SCAN, ST_LST_END
  } state_t;

  state_t state_r;

  logic          issue_r;
  logic [AW-1:0] rd_idx_r;
  logic          rd_pend_r;
  logic [AW-1:0] rd_slot_r;

  logic [bst_pkg::NAME_W-1:0]  name_r;
  logic [bst_pkg::SCORE_W-1:0] score_r;

  logic                        hit_r;
  logic [AW-1:0]               hit_slot_r;
  logic [bst_pkg::SCORE_W-1:0] hit_score_r;
  logic                        minf_r;
  logic [AW-1:0]               min_slot_r;
  logic [bst_pkg::SCORE_W-1:0] min_r;

  logic                        best_f_r;
  logic [AW-1:0]               best_slot_r;
  logic [bst_pkg::SCORE_W-1:0] best_score_r;
  logic [bst_pkg::NAME_W-1:0]  best_name_r;

  // last word sent; also the upper bound on score for the next pass
  logic                        pend_vld_r;
  logic [AW-1:0]               pend_slot_r;
  logic [bst_pkg::SCORE_W-1:0] pend_score_r;
  logic [bst_pkg::NAME_W-1:0]  pend_name_r;

  logic          sub_wr;
  logic [AW-1:0] sub_slot;
  logic          elig;
  logic          lst_go;

  assign sub_wr   = hit_r ? (score_r > hit_score_r) : minf_r;
  assign sub_slot = hit_r ? hit_slot_r : min_slot_r;

  assign elig = (mem_rsp.name[7:0] != 8'h00) &&
                (!pend_vld_r || (mem_rsp.score < pend_score_r) ||
                 ((mem_rsp.score == pend_score_r) && (rd_slot_r > pend_slot_r)));

  assign lst_go = !pend_vld_r || res_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      issue_r    <= 1'b0;
      rd_idx_r   <= '0;
      rd_pend_r  <= 1'b0;
      pend_vld_r <= 1'b0;
      best_f_r   <= 1'b0;
    end else begin
      rd_pend_r <= issue_r;
      rd_slot_r <= rd_idx_r;
      if (issue_r) begin
        if (rd_idx_r == LAST) issue_r <= 1'b0;
        else rd_idx_r <= rd_idx_r + 1'b1;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            name_r     <= bst_pkg::canon_name(in_name);
            score_r    <= in_score;
            min_r      <= in_score;
            hit_r      <= 1'b0;
            minf_r     <= 1'b0;
            best_f_r   <= 1'b0;
            pend_vld_r <= 1'b0;
            if (in_action == bst_pkg::ACT_SUBMIT) begin
              state_r  <= ST_SUB_SCAN;
              issue_r  <= 1'b1;
              rd_idx_r <= '0;
            end else if (in_action == bst_pkg::ACT_LIST) begin
              state_r  <= ST_LST_SCAN;
              issue_r  <= 1'b1;
              rd_idx_r <= '0;
            end
          end
        end
        ST_SUB_SCAN: begin
          if (rd_pend_r) begin
            if (mem_rsp.name == name_r) begin
              hit_r       <= 1'b1;
              hit_slot_r  <= rd_slot_r;
              hit_score_r <= mem_rsp.score;
            end
            if (mem_rsp.score < min_r) begin
              min_r      <= mem_rsp.score;
              minf_r     <= 1'b1;
              min_slot_r <= rd_slot_r;
            end
            if (rd_slot_r == LAST) state_r <= ST_SUB_END;
          end
        end
        ST_SUB_END: begin
          if (res_ready) state_r <= ST_IDLE;
        end
        ST_LST_SCAN: begin
          if (rd_pend_r) begin
            if (elig && (!best_f_r || (mem_rsp.score > best_score_r))) begin
              best_f_r     <= 1'b1;
              best_slot_r  <= rd_slot_r;
              best_score_r <= mem_rsp.score;
              best_name_r  <= mem_rsp.name;
            end
            if (rd_slot_r == LAST) state_r <= ST_LST_END;
          end
        end
        ST_LST_END: begin
          if (lst_go) begin
            if (best_f_r) begin
              pend_vld_r   <= 1'b1;
              pend_slot_r  <= best_slot_r;
              pend_score_r <= best_score_r;
              pend_name_r  <= best_name_r;
              best_f_r     <= 1'b0;
              issue_r      <= 1'b1;
              rd_idx_r     <= '0;
              state_r      <= ST_LST_SCAN;
            end else begin
              pend_vld_r <= 1'b0;
              state_r    <= ST_IDLE;
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    mem_req          = '0;
    mem_req.rd_en    = issue_r;
    mem_req.rd_addr  = bst_pkg::SLOT_W'(rd_idx_r);
    mem_req.wr_en    = (state_r == ST_SUB_END) && res_ready && sub_wr;
    mem_req.wr_addr  = bst_pkg::SLOT_W'(sub_slot);
    mem_req.wr_name  = name_r;
    mem_req.wr_score = score_r;
    mem_req.clr      = (state_r == ST_IDLE) && in_valid && (in_action == bst_pkg::ACT_CLEAR);
  end

  always_comb begin
    res = '0;
    if (state_r == ST_SUB_END) begin
      res.valid   = 1'b1;
      res.slot    = sub_wr ? bst_pkg::SLOT_W'(sub_slot) : '0;
      res.written = sub_wr;
      res.last    = 1'b1;
    end else if (state_r == ST_LST_END) begin
      res.valid = pend_vld_r;
      res.slot  = bst_pkg::SLOT_W'(pend_slot_r);
      res.name  = pend_name_r;
      res.score = pend_score_r;
      res.last  = !best_f_r;
    end
  end

  `BST_CHECK_NOW(a_wr_no_scan, mem_req.wr_en, !mem_req.rd_en && !rd_pend_r)
  `BST_CHECK_NOW(a_wr_reported, mem_req.wr_en, res.valid && res.written && res_ready)
  `BST_CHECK_NEXT(a_list_next_pass,
    (state_r == ST_LST_END) && best_f_r && lst_go, pend_vld_r && issue_r)

endmodule

### hdl/best_score_table_with_ranked_readout.sv
// Best-score table: a submit makes one full pass over all slots and returns one
// word; a list of n entries makes n+1 passes, one per ranked entry and a last
// that finds none; a clear zeroes every slot's valid bit without leaving idle.
// Passes go through the table memory's single read port. One item is in work at a
// time; a finished word waits in the output register while the next item starts.
// Top level; depends on bst_pkg, bst_mem, bst_seq and the assertion macro header.
`include "best_score_table_with_ranked_readout_defines.svh"
module best_score_table_with_ranked_readout #(
  parameter int ENTRIES = 40
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    in_action,
  input  logic [bst_pkg::NAME_W-1:0]    in_player_name,
  input  logic [bst_pkg::SCORE_W-1:0]   in_new_score,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [bst_pkg::SLOT_W-1:0]    out_slot,
  output logic                          out_written,
  output logic [bst_pkg::NAME_W-1:0]    out_entry_name,
  output logic [bst_pkg::SCORE_W-1:0]   out_entry_score,
  output logic                          out_last
);

  bst_pkg::mem_req_t mem_req;
  bst_pkg::mem_rsp_t mem_rsp;
  bst_pkg::res_t     res;
  logic              res_ready;

  logic                        out_valid_r;
  logic [bst_pkg::SLOT_W-1:0]  out_slot_r;
  logic                        out_written_r;
  logic [bst_pkg::NAME_W-1:0]  out_name_r;
  logic [bst_pkg::SCORE_W-1:0] out_score_r;
  logic                        out_last_r;

  bst_mem #(.ENTRIES(ENTRIES)) u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .mem_req (mem_req),
    .mem_rsp (mem_rsp)
  );

  bst_seq #(.ENTRIES(ENTRIES)) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_action (in_action),
    .in_name   (in_player_name),
    .in_score  (in_new_score),
    .mem_req   (mem_req),
    .mem_rsp   (mem_rsp),
    .res       (res),
    .res_ready (res_ready)
  );

  assign res_ready = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res.valid) begin
      out_slot_r    <= res.slot;
      out_written_r <= res.written;
      out_name_r    <= res.name;
      out_score_r   <= res.score;
      out_last_r    <= res.last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_slot        = out_slot_r;
  assign out_written     = out_written_r;
  assign out_entry_name  = out_name_r;
  assign out_entry_score = out_score_r;
  assign out_last        = out_last_r;

  `BST_CHECK_NOW(a_written_last, out_valid && out_written, out_last && (out_entry_score == '0))
  `BST_CHECK_NOW(a_slot_range, out_valid, int'(out_slot) < ENTRIES)
  `BST_CHECK_NEXT(a_submit_busy,
    in_valid && in_ready && (in_action == bst_pkg::ACT_SUBMIT), !in_ready)

endmodule

### tb/best_score_table_with_ranked_readout_test.sv
`timescale 1ns / 1ps
// Testbench for best_score_table_with_ranked_readout: directed and random submit, list and
// clear words, checked against an in-bench score table predictor. Depends on bst_pkg.
module best_score_table_with_ranked_readout_test;

  localparam int          ENTRIES     = 40;
  localparam logic [1:0]  ACT_IGNORED = 2'd3;
  localparam int          IDLE_LIMIT  = 8000;
  localparam int          DRAIN_WAIT  = 2000;
  localparam int          HOLD_CYCLES = 400;
  localparam int          HOLD_AT     = 30;
  localparam int          POOL_SIZE   = 48;
  localparam int          RAND_ITEMS  = 130;

  typedef struct {
    logic [1:0]                  action;
    logic [bst_pkg::NAME_W-1:0]  name;
    logic [bst_pkg::SCORE_W-1:0] score;
  } score_item_t;

  typedef struct {
    logic [bst_pkg::SLOT_W-1:0]  slot;
    logic                        written;
    logic [bst_pkg::NAME_W-1:0]  name;
    logic [bst_pkg::SCORE_W-1:0] score;
    logic                        last;
  } ranked_word_t;

  logic                         clk             = 1'b0;
  logic                         rst_n           = 1'b0;
  logic                         in_valid        = 1'b0;
  logic                         in_ready;
  logic [1:0]                   in_action       = '0;
  logic [bst_pkg::NAME_W-1:0]   in_player_name  = '0;
  logic [bst_pkg::SCORE_W-1:0]  in_new_score    = '0;
  logic                         out_valid;
  logic                         out_ready       = 1'b0;
  logic [bst_pkg::SLOT_W-1:0]   out_slot;
  logic                         out_written;
  logic [bst_pkg::NAME_W-1:0]   out_entry_name;
  logic [bst_pkg::SCORE_W-1:0]  out_entry_score;
  logic                         out_last;

  score_item_t  pending_items[$];
  ranked_word_t expected_words[$];
  logic [bst_pkg::NAME_W-1:0]  tbl_name[ENTRIES];
  logic [bst_pkg::SCORE_W-1:0] tbl_score[ENTRIES];
  logic [bst_pkg::NAME_W-1:0]  name_pool[POOL_SIZE];

  int n_accepted  = 0;
  int idle_cycles = 0;
  int hold_left   = 0;
  bit hold_done   = 1'b0;
  int n_errors    = 0;

  best_score_table_with_ranked_readout #(.ENTRIES(ENTRIES)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_action(in_action),
    .in_player_name(in_player_name), .in_new_score(in_new_score),
    .out_valid(out_valid), .out_ready(out_ready), .out_slot(out_slot),
    .out_written(out_written), .out_entry_name(out_entry_name),
    .out_entry_score(out_entry_score), .out_last(out_last)
  );

  always #6 clk = ~clk;

  // 0 none, 1 sender idles, 2 receiver stalls, 3 both
  function automatic int idle_phase(int idx);
    if (idx < 45) return 0;
    if (idx < 90) return 1;
    if (idx < 135) return 2;
    return 3;
  endfunction

  function automatic logic [bst_pkg::NAME_W-1:0] trim_name(logic [bst_pkg::NAME_W-1:0] raw);
    logic [bst_pkg::NAME_W-1:0] keep;
    int b;
    keep = '0;
    b = 0;
    while (b < 8 && raw[8*b +: 8] != 8'h00) begin
      keep[8*b +: 8] = raw[8*b +: 8];
      b++;
    end
    return keep;
  endfunction

  task automatic clear_score_tbl();
    for (int i = 0; i < ENTRIES; i++) begin
      tbl_name[i]  = '0;
      tbl_score[i] = '0;
    end
  endtask

  task automatic predict_words(logic [1:0] action, logic [bst_pkg::NAME_W-1:0] raw,
                               logic [bst_pkg::SCORE_W-1:0] score);
    logic [bst_pkg::NAME_W-1:0]  key;
    logic [bst_pkg::SCORE_W-1:0] lowest;
    ranked_word_t                w;
    int                          hit;
    int                          rank[ENTRIES];
    int                          n;
    int                          j;
    case (action)
      bst_pkg::ACT_SUBMIT: begin
        key = trim_name(raw);
        hit = -1;
        for (int i = 0; i < ENTRIES; i++) if (tbl_name[i] == key) hit = i;
        if (hit >= 0) begin
          if (score <= tbl_score[hit]) hit = -1;
        end else begin
          lowest = score;
          for (int i = 0; i < ENTRIES; i++) begin
            if (tbl_score[i] < lowest) begin
              lowest = tbl_score[i];
              hit    = i;
            end
          end
        end
        w = '{slot: '0, written: 1'b0, name: '0, score: '0, last: 1'b1};
        if (hit >= 0) begin
          tbl_name[hit]  = key;
          tbl_score[hit] = score;
          w.slot         = bst_pkg::SLOT_W'(hit);
          w.written      = 1'b1;
        end
        expected_words.push_back(w);
      end
      bst_pkg::ACT_LIST: begin
        n = 0;
        for (int i = 0; i < ENTRIES; i++) begin
          if (tbl_name[i][7:0] != 8'h00) begin
            j = n;
            while (j > 0 && tbl_score[rank[j-1]] < tbl_score[i]) begin
              rank[j] = rank[j-1];
              j--;
            end
            rank[j] = i;
            n++;
          end
        end
        for (int k = 0; k < n; k++) begin
          w = '{slot: bst_pkg::SLOT_W'(rank[k]), written: 1'b0, name: tbl_name[rank[k]],
                score: tbl_score[rank[k]], last: (k == n - 1)};
          expected_words.push_back(w);
        end
      end
      bst_pkg::ACT_CLEAR: clear_score_tbl();
      default: ;
    endcase
  endtask

  task automatic push_item(logic [1:0] action, logic [bst_pkg::NAME_W-1:0] name,
                           logic [bst_pkg::SCORE_W-1:0] score);
    score_item_t it;
    it = '{action: action, name: name, score: score};
    pending_items.push_back(it);
  endtask

  task automatic report_mismatch(string what, logic [bst_pkg::NAME_W-1:0] got,
                                 logic [bst_pkg::NAME_W-1:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
    n_errors++;
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        predict_words(in_action, in_player_name, in_new_score);
        n_accepted <= n_accepted + 1;
      end
      if (!in_valid || in_ready) begin
        if (pending_items.size() != 0 &&
            !(idle_phase(n_accepted) == 1 && $urandom_range(0, 99) < 57) &&
            !(idle_phase(n_accepted) == 3 && $urandom_range(0, 99) < 38)) begin
          in_valid       <= 1'b1;
          in_action      <= pending_items[0].action;
          in_player_name <= pending_items[0].name;
          in_new_score   <= pending_items[0].score;
          void'(pending_items.pop_front());
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off to back up the input
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
    end else if (!hold_done && n_accepted == HOLD_AT) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // monitor
  always @(posedge clk) begin
    ranked_word_t w;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_words.size() == 0) begin
          report_mismatch("word with nothing expected, slot", out_slot, '0);
        end else begin
          w = expected_words.pop_front();
          if (out_slot !== w.slot) report_mismatch("slot", out_slot, w.slot);
          if (out_written !== w.written) report_mismatch("written", out_written, w.written);
          if (out_entry_name !== w.name) report_mismatch("entry_name", out_entry_name, w.name);
          if (out_entry_score !== w.score)
            report_mismatch("entry_score", out_entry_score, w.score);
          if (out_last !== w.last) report_mismatch("last", out_last, w.last);
        end
      end
      out_ready <= (hold_left == 0) &&
                   !(idle_phase(n_accepted) == 2 && $urandom_range(0, 99) < 57) &&
                   !(idle_phase(n_accepted) == 3 && $urandom_range(0, 99) < 38);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    do @(negedge clk); while (idle_cycles < IDLE_LIMIT);
    $display("FAIL best_score_table_with_ranked_readout");
    $finish;
  end

  initial begin
    logic [bst_pkg::NAME_W-1:0]  nm;
    logic [bst_pkg::SCORE_W-1:0] sc;
    int                          len;
    int                          r;
    int                          counted;
    logic [1:0]                  act;

    clear_score_tbl();
    for (int p = 0; p < POOL_SIZE; p++) begin
      nm  = '0;
      len = $urandom_range(1, 8);
      for (int b = 0; b < len; b++) nm[8*b +: 8] = 8'($urandom_range(1, 255));
      name_pool[p] = nm;
    end

    push_item(bst_pkg::ACT_LIST, '0, '0);
    push_item(bst_pkg::ACT_SUBMIT, 64'h41, 24'd0);
    push_item(bst_pkg::ACT_SUBMIT, 64'h41, 24'd100);
    push_item(bst_pkg::ACT_SUBMIT, 64'h41, 24'd50);
    push_item(bst_pkg::ACT_SUBMIT, 64'h41, 24'd100);
    push_item(bst_pkg::ACT_SUBMIT, 64'h41, 24'd200);
    push_item(bst_pkg::ACT_SUBMIT, 64'h424F42, 24'd200);
    push_item(bst_pkg::ACT_SUBMIT, 64'h5A5A_0000_0000_4242, 24'd300);
    push_item(bst_pkg::ACT_SUBMIT, 64'h4242, 24'd250);
    push_item(bst_pkg::ACT_SUBMIT, 64'h4242, 24'd400);
    push_item(bst_pkg::ACT_SUBMIT, 64'hFFFF_FFFF_FFFF_FF00, 24'd5);
    push_item(bst_pkg::ACT_SUBMIT, 64'h0, 24'd3);
    push_item(bst_pkg::ACT_SUBMIT, 64'h0, 24'd9);
    push_item(bst_pkg::ACT_SUBMIT, 64'hFFFF_FFFF_FFFF_FFFF, 24'hFFFFFF);
    push_item(bst_pkg::ACT_SUBMIT, 64'h8080_8080_8080_8080, 24'd1);
    push_item(bst_pkg::ACT_LIST, '0, '0);
    push_item(ACT_IGNORED, {$urandom, $urandom}, 24'($urandom));
    push_item(bst_pkg::ACT_LIST, 64'hFFFF_FFFF_FFFF_FFFF, 24'hFFFFFF);
    push_item(bst_pkg::ACT_CLEAR, {$urandom, $urandom}, 24'($urandom));
    push_item(bst_pkg::ACT_LIST, '0, '0);
    push_item(bst_pkg::ACT_SUBMIT, 64'h7F7F_7F7F_7F7F_7F7F, 24'h800000);
    push_item(bst_pkg::ACT_LIST, '0, '0);

    counted = 0;
    while (counted < RAND_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 84) act = bst_pkg::ACT_SUBMIT;
      else if (r < 92) act = bst_pkg::ACT_LIST;
      else if (r < 95) act = bst_pkg::ACT_CLEAR;
      else act = ACT_IGNORED;
      r = $urandom_range(0, 99);
      if (r < 75) begin
        nm = name_pool[$urandom_range(0, POOL_SIZE - 1)];
      end else if (r < 87) begin
        nm = {$urandom, $urandom};
      end else if (r < 95) begin
        // pool name with junk above the terminator
        nm  = name_pool[$urandom_range(0, POOL_SIZE - 1)];
        len = 0;
        while (len < 8 && nm[8*len +: 8] != 8'h00) len++;
        for (int b = len + 1; b < 8; b++) nm[8*b +: 8] = 8'($urandom);
      end else begin
        nm = {$urandom, $urandom} & ~64'hFF;
      end
      r = $urandom_range(0, 99);
      if (r < 40) sc = 24'($urandom);
      else if (r < 80) sc = 24'($urandom_range(0, 1000));
      else if (r < 90) sc = 24'($urandom_range(0, 20));
      else if (r < 95) sc = 24'hFFFFFF;
      else sc = '0;
      push_item(act, nm, sc);
      if (act != ACT_IGNORED) counted++;
    end

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    do @(negedge clk);
    while (!(pending_items.size() == 0 && !in_valid && expected_words.size() == 0));
    repeat (DRAIN_WAIT) @(posedge clk);

    if (n_errors == 0) begin
      $display("PASS best_score_table_with_ranked_readout");
    end else begin
      $display("FAIL best_score_table_with_ranked_readout");
    end
    $finish;
  end

endmodule
